/* src/rqi_pkg.sv */
// ----------------------------------------------------------------------------
// rqi_pkg
// Shared constants and types for the ray / quadrilateral intersection unit.
// ----------------------------------------------------------------------------
package rqi_pkg;

  localparam int COORD_WIDTH = 24;

  // parallel limit register, in units of the determinant LSB
  localparam int               LIMIT_WIDTH = 40;
  localparam logic [39:0]      LIMIT_RESET = 40'd2814749767;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CAST = 1'b1
  } opcode_e;

endpackage

/* src/ray_quad_intersect_unit.sv */
// ----------------------------------------------------------------------------
// ray_quad_intersect_unit
// Ray against stored planar quad, two-triangle edge test, saturated hit point.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the input is not stalled. A load transfer
// writes one quad corner at once and yields no result; a cast transfer runs
// down a pipeline of COORD_WIDTH+13 register stages (37 at the default width)
// and yields one result through the output register on out_valid_o. The depth
// is set by the hit-point divider: one restoring subtract row per quotient bit,
// COORD_WIDTH+1 rows, each shared by the three axes in parallel. Both triangles
// are tested in parallel lanes, so no item waits on another. An output register
// plus a skid register sit behind the pipeline; the input stalls only when both
// are full. Corners must be loaded before a cast reads them.

module ray_quad_intersect_unit #(
  parameter int COORD_WIDTH = rqi_pkg::COORD_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [1:0]                          vertex_index_i,
  input  logic signed [COORD_WIDTH-1:0]       coord_x_i,
  input  logic signed [COORD_WIDTH-1:0]       coord_y_i,
  input  logic signed [COORD_WIDTH-1:0]       coord_z_i,
  input  logic signed [COORD_WIDTH-1:0]       dir_x_i,
  input  logic signed [COORD_WIDTH-1:0]       dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]       dir_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic signed [COORD_WIDTH-1:0]       hit_x_o,
  output logic signed [COORD_WIDTH-1:0]       hit_y_o,
  output logic signed [COORD_WIDTH-1:0]       hit_z_o,
  input  logic                                cfg_we_i,
  input  logic [rqi_pkg::LIMIT_WIDTH-1:0]     cfg_wdata_i
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;          // edge vectors
  localparam int MW   = 2 * EW;          // cross product terms
  localparam int PW   = MW + 1;          // cross products
  localparam int H    = CW + 2;          // low split of a cross product
  localparam int HW   = PW - H;
  localparam int LW   = EW + H + 1;
  localparam int HPW  = EW + HW;
  localparam int DW   = 3 * CW + 6;      // dot products
  localparam int SW   = DW + 1;
  localparam int K    = CW + 2;          // tn chunk, 3*K == DW
  localparam int PPW  = CW + K + 1;
  localparam int PRW  = 4 * CW + 6;      // tn * dir
  localparam int NW   = PRW + 2;         // dividend
  localparam int QB   = CW + 1;          // quotient bits kept
  localparam int RW   = CW + 3;          // origin plus offset
  localparam int NPS  = QB + 12;         // valid-bit stages
  localparam int LIMW = rqi_pkg::LIMIT_WIDTH;

  localparam logic signed [RW-1:0] SMAX = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);

  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};

  // ---------------------------------------------------------------- control
  logic               en;
  logic               in_xfer, cast_xfer;
  logic [NPS-1:0]     v_q;
  logic [LIMW-1:0]    lim_q;
  logic               out_v_q, sk_v_q, take;

  assign en        = !sk_v_q;
  assign in_stall_o = sk_v_q;
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign cast_xfer = in_xfer && (opcode_i == rqi_pkg::OP_CAST);
  assign take      = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= rqi_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      lim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NPS-2:0], cast_xfer};
    end
  end

  // ---------------------------------------------------------------- corners
  logic signed [CW-1:0] vtx_q [4][3];
  logic signed [CW-1:0] in_o  [3];
  logic signed [CW-1:0] in_d  [3];

  assign in_o[0] = coord_x_i;
  assign in_o[1] = coord_y_i;
  assign in_o[2] = coord_z_i;
  assign in_d[0] = dir_x_i;
  assign in_d[1] = dir_y_i;
  assign in_d[2] = dir_z_i;

  always_ff @(posedge clk_i) begin
    if (in_xfer && (opcode_i == rqi_pkg::OP_LOAD)) begin
      for (int i = 0; i < 3; i++) begin
        vtx_q[vertex_index_i][i] <= in_o[i];
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  // e*: 0 eabA, 1 eacA, 2 tA, 3 eabB, 4 eacB, 5 tB
  logic signed [EW-1:0]  e1_q [6][3];
  logic signed [CW-1:0]  d1_q [3], o1_q [3];
  logic signed [EW-1:0]  e2_q [6][3];
  logic signed [CW-1:0]  d2_q [3], o2_q [3];
  logic signed [MW-1:0]  m2_q [4][6];
  logic signed [EW-1:0]  xa [4][3], xb [4][3];
  logic signed [PW-1:0]  pq [4][3];
  logic signed [EW-1:0]  da3_q [7][3];
  logic signed [PW-1:0]  db3_q [7][3];
  logic signed [CW-1:0]  d3_q [3], o3_q [3];
  logic signed [LW-1:0]  lo4_q [7][3];
  logic signed [HPW-1:0] hi4_q [7][3];
  logic signed [CW-1:0]  d4_q [3], o4_q [3];
  logic signed [DW-1:0]  pr5_q [7][3];
  logic signed [CW-1:0]  d5_q [3], o5_q [3];
  logic signed [DW-1:0]  dt6_q [7];
  logic signed [CW-1:0]  d6_q [3], o6_q [3];
  // stage 7
  logic [DW-1:0]         absa7_q, absb7_q;
  logic                  za7_q, zb7_q, naan7_q, nabn7_q, nban7_q, nbbn7_q, ntn7_q;
  logic signed [SW-1:0]  s7_q;
  logic signed [DW-1:0]  det7_q;
  logic signed [PPW-1:0] pp7_q [3][3];
  logic signed [CW-1:0]  o7_q [3];
  // stage 8
  logic                  hit8_q, dneg8_q;
  logic [DW-1:0]         md8_q;
  logic signed [PRW-1:0] prod8_q [3];
  logic signed [CW-1:0]  o8_q [3];
  // stage 9
  logic                  hit9_q;
  logic [DW-1:0]         md9_q;
  logic [PRW-1:0]        absp9_q [3];
  logic                  flip9_q [3];
  logic signed [CW-1:0]  o9_q [3];
  // stage 10
  logic                  hit10_q;
  logic [NW-1:0]         num10_q [3];
  logic [DW:0]           den10_q;
  logic                  flip10_q [3];
  logic signed [CW-1:0]  o10_q [3];
  // divider rows, row 0 holds the overflow check
  logic [NW-1:0]         dv_rem_q  [QB+1][3];
  logic [QB-1:0]         dv_quo_q  [QB+1][3];
  logic                  dv_ovf_q  [QB+1][3];
  logic                  dv_flip_q [QB+1][3];
  logic signed [CW-1:0]  dv_o_q    [QB+1][3];
  logic [DW:0]           dv_den_q  [QB+1];
  logic                  dv_hit_q  [QB+1];
  logic [NW-1:0]         rw_rem_d  [QB][3];
  logic [QB-1:0]         rw_quo_d  [QB][3];
  // final
  logic                  fin_hit_d, fin_hit_q;
  logic signed [CW-1:0]  fin_xyz_d [3], fin_xyz_q [3];
  logic                  out_hit_q, sk_hit_q;
  logic signed [CW-1:0]  out_xyz_q [3], sk_xyz_q [3];

  function automatic logic negq(input logic signed [DW-1:0] n, input logic dneg);
    return (n != '0) && (n[DW-1] != dneg);
  endfunction

  // cross operands: pA = d x eacA, qA = tA x eabA, pB = d x eacB, qB = tB x eabB
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xa[0][i] = EW'(d1_q[i]);  xb[0][i] = e1_q[1][i];
      xa[1][i] = e1_q[2][i];    xb[1][i] = e1_q[0][i];
      xa[2][i] = EW'(d1_q[i]);  xb[2][i] = e1_q[4][i];
      xa[3][i] = e1_q[5][i];    xb[3][i] = e1_q[3][i];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 3; i++) begin
        pq[c][i] = PW'(m2_q[c][2*i]) - PW'(m2_q[c][2*i+1]);
      end
    end
  end

  // restoring division rows
  always_comb begin
    logic [NW-1:0] trial;
    for (int r = 0; r < QB; r++) begin
      for (int a = 0; a < 3; a++) begin
        trial = NW'(dv_den_q[r]) << (QB - 1 - r);
        if (dv_rem_q[r][a] >= trial) begin
          rw_rem_d[r][a] = dv_rem_q[r][a] - trial;
          rw_quo_d[r][a] = {dv_quo_q[r][a][QB-2:0], 1'b1};
        end else begin
          rw_rem_d[r][a] = dv_rem_q[r][a];
          rw_quo_d[r][a] = {dv_quo_q[r][a][QB-2:0], 1'b0};
        end
      end
    end
  end

  // sign, add origin, saturate
  always_comb begin
    logic signed [QB:0]   sq;
    logic signed [RW-1:0] s;
    fin_hit_d = dv_hit_q[QB];
    for (int a = 0; a < 3; a++) begin
      sq = dv_flip_q[QB][a] ? -$signed({1'b0, dv_quo_q[QB][a]})
                            :  $signed({1'b0, dv_quo_q[QB][a]});
      s  = RW'(dv_o_q[QB][a]) + RW'(sq);
      if (dv_ovf_q[QB][a]) begin
        s = dv_flip_q[QB][a] ? SMIN : SMAX;
      end else if (s > SMAX) begin
        s = SMAX;
      end else if (s < SMIN) begin
        s = SMIN;
      end
      fin_xyz_d[a] = dv_hit_q[QB] ? s[CW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1: edges, triangle A apex V0, triangle B apex V2
      for (int i = 0; i < 3; i++) begin
        e1_q[0][i] <= EW'(vtx_q[1][i]) - EW'(vtx_q[0][i]);
        e1_q[1][i] <= EW'(vtx_q[3][i]) - EW'(vtx_q[0][i]);
        e1_q[2][i] <= EW'(in_o[i])     - EW'(vtx_q[0][i]);
        e1_q[3][i] <= EW'(vtx_q[1][i]) - EW'(vtx_q[2][i]);
        e1_q[4][i] <= EW'(vtx_q[3][i]) - EW'(vtx_q[2][i]);
        e1_q[5][i] <= EW'(in_o[i])     - EW'(vtx_q[2][i]);
        d1_q[i] <= in_d[i];
        o1_q[i] <= in_o[i];
      end
      // stage 2: cross product terms
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 3; i++) begin
          m2_q[c][2*i]   <= xa[c][NX1[i]] * xb[c][NX2[i]];
          m2_q[c][2*i+1] <= xa[c][NX2[i]] * xb[c][NX1[i]];
        end
      end
      e2_q <= e1_q;
      d2_q <= d1_q;
      o2_q <= o1_q;
      // stage 3: cross products, dot operands
      // 0 detA 1 anA 2 bnA 3 tnA 4 detB 5 anB 6 bnB
      for (int i = 0; i < 3; i++) begin
        da3_q[0][i] <= e2_q[0][i];     db3_q[0][i] <= pq[0][i];
        da3_q[1][i] <= e2_q[2][i];     db3_q[1][i] <= pq[0][i];
        da3_q[2][i] <= EW'(d2_q[i]);   db3_q[2][i] <= pq[1][i];
        da3_q[3][i] <= e2_q[1][i];     db3_q[3][i] <= pq[1][i];
        da3_q[4][i] <= e2_q[3][i];     db3_q[4][i] <= pq[2][i];
        da3_q[5][i] <= e2_q[5][i];     db3_q[5][i] <= pq[2][i];
        da3_q[6][i] <= EW'(d2_q[i]);   db3_q[6][i] <= pq[3][i];
      end
      d3_q <= d2_q;
      o3_q <= o2_q;
      // stage 4: split partial products
      for (int j = 0; j < 7; j++) begin
        for (int i = 0; i < 3; i++) begin
          lo4_q[j][i] <= da3_q[j][i] * $signed({1'b0, db3_q[j][i][H-1:0]});
          hi4_q[j][i] <= da3_q[j][i] * $signed(db3_q[j][i][PW-1:H]);
        end
      end
      d4_q <= d3_q;
      o4_q <= o3_q;
      // stage 5: recombine
      for (int j = 0; j < 7; j++) begin
        for (int i = 0; i < 3; i++) begin
          pr5_q[j][i] <= (DW'(hi4_q[j][i]) <<< H) + DW'(lo4_q[j][i]);
        end
      end
      d5_q <= d4_q;
      o5_q <= o4_q;
      // stage 6: dot sums
      for (int j = 0; j < 7; j++) begin
        dt6_q[j] <= pr5_q[j][0] + pr5_q[j][1] + pr5_q[j][2];
      end
      d6_q <= d5_q;
      o6_q <= o5_q;
      // stage 7: signs, magnitudes, tn * dir partials
      absa7_q <= dt6_q[0][DW-1] ? DW'(-dt6_q[0]) : DW'(dt6_q[0]);
      absb7_q <= dt6_q[4][DW-1] ? DW'(-dt6_q[4]) : DW'(dt6_q[4]);
      za7_q   <= (dt6_q[0] == '0);
      zb7_q   <= (dt6_q[4] == '0);
      naan7_q <= negq(dt6_q[1], dt6_q[0][DW-1]);
      nabn7_q <= negq(dt6_q[2], dt6_q[0][DW-1]);
      ntn7_q  <= negq(dt6_q[3], dt6_q[0][DW-1]);
      nban7_q <= negq(dt6_q[5], dt6_q[4][DW-1]);
      nbbn7_q <= negq(dt6_q[6], dt6_q[4][DW-1]);
      s7_q    <= SW'(dt6_q[1]) + SW'(dt6_q[2]);
      det7_q  <= dt6_q[0];
      for (int a = 0; a < 3; a++) begin
        pp7_q[a][0] <= d6_q[a] * $signed({1'b0, dt6_q[3][K-1:0]});
        pp7_q[a][1] <= d6_q[a] * $signed({1'b0, dt6_q[3][2*K-1:K]});
        pp7_q[a][2] <= d6_q[a] * $signed(dt6_q[3][3*K-1:2*K]);
      end
      o7_q <= o6_q;
      // stage 8: parallel and over tests, full product
      // second triangle matters only when alpha + beta exceeds one
      hit8_q <= !(za7_q || (absa7_q < DW'(lim_q))) && !naan7_q && !nabn7_q && !ntn7_q &&
                (!(det7_q[DW-1] ? (SW'(det7_q) > s7_q) : (s7_q > SW'(det7_q))) ||
                 (!(zb7_q || (absb7_q < DW'(lim_q))) && !nban7_q && !nbbn7_q));
      dneg8_q <= det7_q[DW-1];
      md8_q   <= absa7_q;
      for (int a = 0; a < 3; a++) begin
        prod8_q[a] <= (PRW'(pp7_q[a][2]) <<< (2 * K)) + (PRW'(pp7_q[a][1]) <<< K) +
                      PRW'(pp7_q[a][0]);
      end
      o8_q <= o7_q;
      // stage 9
      hit9_q <= hit8_q;
      md9_q  <= md8_q;
      for (int a = 0; a < 3; a++) begin
        absp9_q[a] <= prod8_q[a][PRW-1] ? PRW'(-prod8_q[a]) : PRW'(prod8_q[a]);
        flip9_q[a] <= prod8_q[a][PRW-1] ^ dneg8_q;
      end
      o9_q <= o8_q;
      // stage 10: round to nearest as (2|p| + |det|) / 2|det|
      hit10_q <= hit9_q;
      den10_q <= {md9_q, 1'b0};
      for (int a = 0; a < 3; a++) begin
        num10_q[a] <= (NW'(absp9_q[a]) << 1) + NW'(md9_q);
      end
      flip10_q <= flip9_q;
      o10_q    <= o9_q;
      // row 0: quotient too wide to matter means saturation
      dv_den_q[0] <= den10_q;
      dv_hit_q[0] <= hit10_q;
      for (int a = 0; a < 3; a++) begin
        dv_rem_q[0][a]  <= num10_q[a];
        dv_quo_q[0][a]  <= '0;
        dv_ovf_q[0][a]  <= (num10_q[a] >= (NW'(den10_q) << QB));
        dv_flip_q[0][a] <= flip10_q[a];
        dv_o_q[0][a]    <= o10_q[a];
      end
      for (int r = 0; r < QB; r++) begin
        dv_den_q[r+1] <= dv_den_q[r];
        dv_hit_q[r+1] <= dv_hit_q[r];
        for (int a = 0; a < 3; a++) begin
          dv_rem_q[r+1][a]  <= rw_rem_d[r][a];
          dv_quo_q[r+1][a]  <= rw_quo_d[r][a];
          dv_ovf_q[r+1][a]  <= dv_ovf_q[r][a];
          dv_flip_q[r+1][a] <= dv_flip_q[r][a];
          dv_o_q[r+1][a]    <= dv_o_q[r][a];
        end
      end
      fin_hit_q <= fin_hit_d;
      fin_xyz_q <= fin_xyz_d;
    end
  end

  // ---------------------------------------------------------------- output + skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (take || !out_v_q) begin
      if (sk_v_q) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end else begin
        out_v_q <= v_q[NPS-1];
      end
    end else if (v_q[NPS-1]) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take || !out_v_q) begin
      if (sk_v_q) begin
        out_hit_q <= sk_hit_q;
        out_xyz_q <= sk_xyz_q;
      end else begin
        out_hit_q <= fin_hit_q;
        out_xyz_q <= fin_xyz_q;
      end
    end else if (en && v_q[NPS-1]) begin
      sk_hit_q <= fin_hit_q;
      sk_xyz_q <= fin_xyz_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign hit_o       = out_hit_q;
  assign hit_x_o     = out_xyz_q[0];
  assign hit_y_o     = out_xyz_q[1];
  assign hit_z_o     = out_xyz_q[2];

endmodule

/* src/rqi_checker.sv */
// ----------------------------------------------------------------------------
// rqi_checker
// Port-level checks for the ray / quadrilateral intersection unit.
// ----------------------------------------------------------------------------
module rqi_checker #(
  parameter int COORD_WIDTH = rqi_pkg::COORD_WIDTH
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          hit_o,
  input logic signed [COORD_WIDTH-1:0] hit_x_o,
  input logic signed [COORD_WIDTH-1:0] hit_y_o,
  input logic signed [COORD_WIDTH-1:0] hit_z_o
);

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0)
    else $error("miss result with nonzero point");

  // input backs up only behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) &&
      $stable(hit_x_o) && $stable(hit_y_o) && $stable(hit_z_o))
    else $error("stalled result changed");

endmodule

bind ray_quad_intersect_unit rqi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rqi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o),
  .hit_x_o     (hit_x_o),
  .hit_y_o     (hit_y_o),
  .hit_z_o     (hit_z_o)
);

/* verif/ray_quad_intersect_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_quad_intersect_unit_tb
// Loads quad corners and casts rays through the intersection unit. Each cast
// is predicted with exact wide integer arithmetic and checked field by field
// against the unit's result. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module ray_quad_intersect_unit_tb;

  localparam int CW = rqi_pkg::COORD_WIDTH;
  localparam int LAT = CW + 13;
  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [199:0] wide_t;
  typedef struct packed {
    logic   hit;
    coord_t x, y, z;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = rqi_pkg::OP_LOAD;
  logic [1:0] vertex_index_i = '0;
  coord_t coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  coord_t dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  coord_t hit_x_o, hit_y_o, hit_z_o;
  logic cfg_we_i = 1'b0;
  logic [rqi_pkg::LIMIT_WIDTH-1:0] cfg_wdata_i = '0;

  ray_quad_intersect_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .vertex_index_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .out_valid_o, .out_stall_i, .hit_o, .hit_x_o, .hit_y_o, .hit_z_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model state
  coord_t corner_store [4][3];
  logic [rqi_pkg::LIMIT_WIDTH-1:0] limit_shadow = rqi_pkg::LIMIT_RESET;
  hit_t expected_hits [$];
  int errors = 0;
  int casts_sent = 0, hits_seen = 0, results_seen = 0;
  int hold_off = 0;     // long receiver hold-off, in cycles
  bit stall_mode = 0;   // 0: no stalls, 1: random stalls
  int gap_max = 3;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic wide_t wabs(input wide_t a);
    return a < 0 ? -a : a;
  endfunction

  function automatic bit is_neg_ratio(input wide_t num, input wide_t det);
    return num != 0 && ((num < 0) != (det < 0));
  endfunction

  function automatic void cross3(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
    r[0] = a[1]*b[2] - a[2]*b[1];
    r[1] = a[2]*b[0] - a[0]*b[2];
    r[2] = a[0]*b[1] - a[1]*b[0];
  endfunction

  function automatic wide_t dot3(input wide_t a[3], input wide_t b[3]);
    return a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
  endfunction

  // edge test on triangle apex a, b, c
  function automatic bit tri_pass(input wide_t a[3], input wide_t b[3], input wide_t c[3],
                                  input wide_t o[3], input wide_t d[3],
                                  output wide_t det, output wide_t an, output wide_t bn,
                                  output wide_t q[3], output wide_t e_ac[3]);
    wide_t e_ab[3], p[3], t[3];
    for (int i = 0; i < 3; i++) begin
      e_ab[i] = b[i] - a[i];
      e_ac[i] = c[i] - a[i];
      t[i] = o[i] - a[i];
    end
    cross3(d, e_ac, p);
    det = dot3(e_ab, p);
    an = 0; bn = 0;
    for (int i = 0; i < 3; i++) q[i] = 0;
    if (det == 0 || wabs(det) < wide_t'(limit_shadow)) return 0;
    an = dot3(t, p);
    if (is_neg_ratio(an, det)) return 0;
    cross3(t, e_ab, q);
    bn = dot3(d, q);
    if (is_neg_ratio(bn, det)) return 0;
    return 1;
  endfunction

  function automatic hit_t predict_hit(input coord_t ox, oy, oz, dx, dy, dz);
    wide_t v[4][3], o[3], d[3], det, an, bn, q[3], e03[3];
    wide_t det2, an2, bn2, q2[3], e21[3], tn, prod, md, qq, s, sum;
    hit_t r;
    bit over;
    r = '0;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++) v[i][k] = corner_store[i][k];
    o[0] = ox; o[1] = oy; o[2] = oz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    if (!tri_pass(v[0], v[1], v[3], o, d, det, an, bn, q, e03)) return r;
    sum = an + bn;
    over = det < 0 ? (det > sum) : (sum > det);
    if (over && !tri_pass(v[2], v[1], v[3], o, d, det2, an2, bn2, q2, e21)) return r;
    tn = dot3(e03, q);
    if (is_neg_ratio(tn, det)) return r;
    r.hit = 1'b1;
    md = wabs(det);
    for (int i = 0; i < 3; i++) begin
      prod = tn * d[i];
      // round half away from zero on magnitude, then restore sign
      qq = (2*wabs(prod) + md) / (2*md);
      if ((prod < 0) != (det < 0)) qq = -qq;
      s = o[i] + qq;
      if (s > wide_t'(coord_t'({1'b0, {(CW-1){1'b1}}}))) s = {1'b0, {(CW-1){1'b1}}};
      if (s < wide_t'(coord_t'({1'b1, {(CW-1){1'b0}}}))) s = -(wide_t'(1) <<< (CW-1));
      case (i)
        0: r.x = s[CW-1:0];
        1: r.y = s[CW-1:0];
        default: r.z = s[CW-1:0];
      endcase
    end
    return r;
  endfunction

  // one transfer on the input channel; driven at the falling edge. Valid stays
  // up on return so the next call can follow back to back; idle callers drop it.
  task automatic send_item(input logic op, input logic [1:0] idx,
                           input coord_t cx, cy, cz, dx, dy, dz);
    int gap;
    gap = $urandom_range(0, 7) == 0 ? $urandom_range(1, gap_max) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op; vertex_index_i <= idx;
    coord_x_i <= cx; coord_y_i <= cy; coord_z_i <= cz;
    dir_x_i <= dx; dir_y_i <= dy; dir_z_i <= dz;
    do @(posedge clk_i); while (in_stall_o);
    if (op == rqi_pkg::OP_LOAD) begin
      corner_store[idx][0] = cx; corner_store[idx][1] = cy; corner_store[idx][2] = cz;
    end else begin
      expected_hits.push_back(predict_hit(cx, cy, cz, dx, dy, dz));
      casts_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic load_corner(input logic [1:0] idx, input coord_t x, y, z);
    send_item(rqi_pkg::OP_LOAD, idx, x, y, z, $urandom, $urandom, $urandom);
  endtask

  task automatic cast_ray(input coord_t ox, oy, oz, dx, dy, dz);
    send_item(rqi_pkg::OP_CAST, $urandom, ox, oy, oz, dx, dy, dz);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(negedge clk_i);
    repeat (LAT + 4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [rqi_pkg::LIMIT_WIDTH-1:0] val);
    drain();
    cfg_we_i <= 1'b1; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_shadow = val;
  endtask

  // square of half-side s in the plane at height z, corners in winding order, scale s in Q8.16
  task automatic load_square(input int s, input int z);
    load_corner(0, -s, -s, z);
    load_corner(1,  s, -s, z);
    load_corner(2,  s,  s, z);
    load_corner(3, -s,  s, z);
  endtask

  function automatic coord_t rnd_coord(input int mag);
    int r;
    r = $urandom_range(0, 2*mag) - mag;
    return coord_t'(r);
  endfunction

  function automatic coord_t rnd_full();
    return coord_t'($urandom);
  endfunction

  task automatic test_directed();
    load_square(32'h10000, 0);
    cast_ray(0, 0, 32'h20000, 0, 0, -32'h10000);                 // center hit
    cast_ray(32'h8000, 32'h8000, 32'h20000, 0, 0, -32'h10000);   // second triangle
    cast_ray(32'h30000, 0, 32'h20000, 0, 0, -32'h10000);         // outside
    cast_ray(0, 0, 32'h20000, 0, 0, 32'h10000);                  // behind origin
    cast_ray(0, 0, 32'h20000, 32'h10000, 0, 0);                  // parallel
    cast_ray(0, 0, 0, 0, 0, -32'h10000);                         // origin on quad
    cast_ray(-32'h10000, -32'h10000, 32'h10000, 0, 0, -32'h10000); // corner, zero bary
    cast_ray(32'h10000, 32'h10000, 32'h10000, 0, 0, -32'h10000);
    cast_ray(32'h7fffff, 32'h7fffff, 32'h7fffff, -32'h800000, -32'h800000, -32'h800000);
    cast_ray(-32'h800000, -32'h800000, -32'h800000, 32'h7fffff, 32'h7fffff, 32'h7fffff);
    cast_ray(0, 0, 1, 32'h7fffff, 32'h7fffff, -1);               // hit point outside the quad
    cast_ray(0, 0, -1, -32'h800000, 32'h7fffff, 1);
    load_square(32'h7fffff, -32'h800000);
    cast_ray(0, 0, 32'h7fffff, 1, -1, -32'h800000);
    cast_ray(0, 0, 32'h7fffff, 0, 0, 1);
    load_square(32'h10000, 0);
    cast_ray(0, 0, 32'h10000, 0, 0, -1);                         // tiny dir, small det
  endtask

  task automatic test_limit_settings();
    logic [rqi_pkg::LIMIT_WIDTH-1:0] lims[4];
    lims[0] = '0; lims[1] = '1; lims[2] = 40'd1 << 32; lims[3] = rqi_pkg::LIMIT_RESET;
    foreach (lims[i]) begin
      write_limit(lims[i]);
      load_square(32'h10000, 0);
      repeat (20) cast_ray(rnd_coord(32'h18000), rnd_coord(32'h18000), rnd_coord(32'h40000),
                           rnd_coord(32'h400), rnd_coord(32'h400), rnd_coord(32'h20000));
      cast_ray(0, 0, 32'h10000, 1, 0, 0);                        // det exactly zero
    end
  endtask

  task automatic test_random();
    int n;
    n = 0;
    gap_max = 6;
    while (n < 1300) begin
      if ($urandom_range(0, 9) == 0) begin
        load_corner($urandom, rnd_full(), rnd_full(), rnd_full());
      end else if ($urandom_range(0, 19) == 0) begin
        for (int c = 0; c < 4; c++)
          load_corner(c, rnd_coord(32'h40000), rnd_coord(32'h40000), rnd_coord(32'h40000));
      end
      if ($urandom_range(0, 5) == 0)
        cast_ray(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full());
      else
        cast_ray(rnd_coord(32'h40000), rnd_coord(32'h40000), rnd_coord(32'h40000),
                 rnd_coord(32'h30000), rnd_coord(32'h30000), rnd_coord(32'h30000));
      n++;
      if (n % 300 == 0) stall_mode = ~stall_mode;
    end
  endtask

  task automatic test_backpressure();
    hold_off = 200;
    repeat (80) cast_ray(rnd_coord(32'h18000), rnd_coord(32'h18000), 32'h20000,
                         rnd_coord(32'h800), rnd_coord(32'h800), -32'h10000);
    drain();   // sender idles until every result is back
    repeat (20) cast_ray(rnd_coord(32'h18000), rnd_coord(32'h18000), 32'h20000,
                         0, 0, -32'h10000);
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off = hold_off - 1;
    end else if (stall_mode)
      out_stall_i <= ($urandom_range(0, 3) == 0);
    else
      out_stall_i <= 1'b0;
  end

  // result checker
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        want = expected_hits.pop_front();
        if (want.hit) hits_seen++;
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (hit_x_o !== want.x) report_mismatch("hit_x", hit_x_o, want.x);
        if (hit_y_o !== want.y) report_mismatch("hit_y", hit_y_o, want.y);
        if (hit_z_o !== want.z) report_mismatch("hit_z", hit_z_o, want.z);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("ray_quad_intersect_unit_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    stall_mode = 1;
    test_limit_settings();
    test_random();
    stall_mode = 0;
    test_backpressure();
    stall_mode = 1;
    drain();
    if (expected_hits.size() != 0) begin
      report_mismatch("results never arrived", 0, expected_hits.size());
    end
    $display("covered %0d casts, %0d results, %0d hits, limits 0/max/mid/reset",
             casts_sent, results_seen, hits_seen);
    if (errors == 0)
      $display("ray_quad_intersect_unit_tb: PASS");
    else
      $display("ray_quad_intersect_unit_tb: FAIL");
    $finish;
  end
endmodule

/* ray_quad_intersect_unit.f */
src/rqi_pkg.sv
src/ray_quad_intersect_unit.sv
src/rqi_checker.sv
verif/ray_quad_intersect_unit_tb.sv
